@@ rtl/stt_pkg.sv @@
package stt_pkg;

  // Default sizes and fixed widths.
  localparam int unsigned LEN_MAX_DEF  = 65535;
  localparam int unsigned KW_CHARS_DEF = 8;
  localparam int unsigned MAX_RES      = 4;
  localparam int unsigned CNT_W        = $clog2(MAX_RES + 1);
  localparam int unsigned RES_IW       = $clog2(MAX_RES);
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QIW          = $clog2(QDEPTH);
  localparam int unsigned QCW          = $clog2(QDEPTH + 1);
  localparam int unsigned NUM_KW       = 14;

  // Character codes.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_US    = 8'h5F;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_STRING, M_NUMBER, M_COMMENT, M_PEND1, M_PEND2
  } mode_t;

  typedef enum logic [3:0] {
    K_IDENT, K_KEYWORD, K_STRING, K_INT, K_FLOAT, K_PUNCT, K_MULTI, K_DOTS, K_END
  } kind_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  code;
    logic [23:0] line;
    logic [31:0] start;
    logic [15:0] len;
  } tok_t;

  // All results caused by one accepted byte.
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    tok_t [MAX_RES-1:0]      tok;
  } bundle_t;

  function automatic tok_t mk(input logic [3:0] kind, input logic [7:0] code,
                              input logic [23:0] line, input logic [31:0] start,
                              input logic [15:0] len);
    tok_t t;
    t.kind  = kind;
    t.code  = code;
    t.line  = line;
    t.start = start;
    t.len   = len;
    return t;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_US);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic starts_multi(input logic [7:0] c);
    logic r;
    case (c)
      "&", "|", ">", "<", "+", "-", "*", "/", "%", "^", "=", "!", ":", ".": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Pairs that may grow into a three-character token.
  function automatic logic prefix3(input logic [7:0] a, input logic [7:0] b);
    return (a == ">" && b == ">") || (a == "<" && b == "<") ||
           (a == "-" && b == ">") || (a == "." && b == ".");
  endfunction

  // Two-character operator lookup: {hit, index}.
  function automatic logic [5:0] op2(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] r;
    case ({a, b})
      "&&": r = {1'b1, 5'd0};
      "||": r = {1'b1, 5'd1};
      ">>": r = {1'b1, 5'd2};
      "<<": r = {1'b1, 5'd3};
      "++": r = {1'b1, 5'd4};
      "+=": r = {1'b1, 5'd5};
      "--": r = {1'b1, 5'd6};
      "-=": r = {1'b1, 5'd7};
      "*=": r = {1'b1, 5'd8};
      "/=": r = {1'b1, 5'd9};
      "%=": r = {1'b1, 5'd10};
      "&=": r = {1'b1, 5'd11};
      "|=": r = {1'b1, 5'd12};
      "^=": r = {1'b1, 5'd13};
      "==": r = {1'b1, 5'd17};
      "!=": r = {1'b1, 5'd18};
      ">=": r = {1'b1, 5'd19};
      "<=": r = {1'b1, 5'd20};
      "->": r = {1'b1, 5'd21};
      ":=": r = {1'b1, 5'd22};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // Three-character operator lookup: {hit, index}.
  function automatic logic [5:0] op3(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    logic [5:0] r;
    case ({a, b, c})
      ">>=": r = {1'b1, 5'd14};
      "<<=": r = {1'b1, 5'd15};
      "->=": r = {1'b1, 5'd16};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] i);
    logic [3:0] r;
    case (i)
      4'd0, 4'd4: r = 4'd2;
      4'd11: r = 4'd3;
      4'd1, 4'd2, 4'd5, 4'd8: r = 4'd4;
      4'd3, 4'd10, 4'd13: r = 4'd5;
      4'd6, 4'd7, 4'd12: r = 4'd6;
      4'd9: r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Keyword text, first character in the top byte, zero padded.
  function automatic logic [63:0] kw_word(input logic [3:0] i);
    logic [63:0] lit;
    case (i)
      4'd0:  lit = 64'("if");
      4'd1:  lit = 64'("else");
      4'd2:  lit = 64'("elif");
      4'd3:  lit = 64'("while");
      4'd4:  lit = 64'("do");
      4'd5:  lit = 64'("func");
      4'd6:  lit = 64'("return");
      4'd7:  lit = 64'("switch");
      4'd8:  lit = 64'("case");
      4'd9:  lit = 64'("continue");
      4'd10: lit = 64'("break");
      4'd11: lit = 64'("for");
      4'd12: lit = 64'("struct");
      4'd13: lit = 64'("cfunc");
      default: lit = 64'd0;
    endcase
    return lit << (8 * (8 - int'(kw_len(i))));
  endfunction

endpackage

@@ rtl/stt_front.sv @@
module stt_front #(
  parameter int unsigned LEN_MAX       = stt_pkg::LEN_MAX_DEF,
  parameter int unsigned KEYWORD_CHARS = stt_pkg::KW_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_i,
  input  logic [7:0]       chr_i,
  input  logic             eoi_i,
  output stt_pkg::bundle_t bun_o,
  output logic             bun_push_o
);
  import stt_pkg::*;

  localparam int unsigned LEN_W = $clog2(LEN_MAX + 1);
  localparam int unsigned KW_IW = $clog2(KEYWORD_CHARS);

  typedef logic [KEYWORD_CHARS-1:0][7:0] kwv_t;

  mode_t             mode_r, mode_nxt;
  logic [23:0]       line_r, line_nxt;
  logic [31:0]       byte_r;
  logic [31:0]       start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt, len_inc;
  kwv_t              kw_r, kw_nxt;
  logic [7:0]        p0_r, p0_nxt, p1_r, p1_nxt;
  logic              dot_r, dot_nxt;
  logic              idle_go;
  logic [5:0]        op2_cur, op2_pp, op2_fl, op3_cur;
  logic              dots_hit;
  tok_t [5:0]        sl;
  logic [5:0]        sv;
  logic [CNT_W-1:0]  n;
  logic [7:0]        c;

  function automatic logic [4:0] kw_find(input kwv_t kw, input logic [LEN_W-1:0] len);
    logic [63:0] txt;
    logic [4:0]  r;
    txt = '0;
    r   = '0;
    for (int b = 0; b < 8; b++) begin
      txt[63-8*b -: 8] = kw[b];
    end
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (len == LEN_W'(kw_len(4'(i))) && txt == kw_word(4'(i))) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

  function automatic tok_t ident_tok(input kwv_t kw, input logic [LEN_W-1:0] len,
                                     input logic [31:0] st, input logic [23:0] ln);
    logic [4:0] f;
    f = kw_find(kw, len);
    if (f[4]) begin
      return mk(K_KEYWORD, {4'd0, f[3:0]}, ln, st, 16'(len));
    end
    return mk(K_IDENT, 8'd0, ln, st, 16'(len));
  endfunction

  assign c        = chr_i;
  assign len_inc  = (len_r < LEN_W'(LEN_MAX)) ? len_r + LEN_W'(1) : len_r;
  assign op2_cur  = op2(p0_r, c);
  assign op2_pp   = op2(p0_r, p1_r);
  assign op2_fl   = op2(p0_nxt, p1_nxt);
  assign op3_cur  = op3(p0_r, p1_r, c);
  assign dots_hit = (p0_r == CH_DOT) && (p1_r == CH_DOT) && (c == CH_DOT);

  // Next scanner state after taking the byte.
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    kw_nxt    = kw_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    dot_nxt   = dot_r;
    idle_go   = 1'b0;
    unique case (mode_r)
      M_IDENT: begin
        if (is_word(c)) begin
          if (len_r < LEN_W'(KEYWORD_CHARS)) begin
            kw_nxt[len_r[KW_IW-1:0]] = c;
          end
          len_nxt = len_inc;
        end else begin
          idle_go = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(c) || c == CH_DOT) begin
          if (c == CH_DOT) begin
            dot_nxt = 1'b1;
          end
          len_nxt = len_inc;
        end else begin
          idle_go = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          mode_nxt = M_IDLE;
        end else begin
          len_nxt = len_inc;
        end
      end
      M_COMMENT: begin
        if (c == CH_SLASH && dot_r) begin
          mode_nxt = M_IDLE;
        end else if (c == CH_NL) begin
          line_nxt = line_r + 24'd1;
        end
        dot_nxt = (c == CH_STAR);
      end
      M_PEND1: begin
        if (p0_r == CH_SLASH && c == CH_STAR) begin
          mode_nxt = M_COMMENT;
          dot_nxt  = 1'b0;
        end else if (prefix3(p0_r, c)) begin
          p1_nxt   = c;
          mode_nxt = M_PEND2;
        end else if (op2_cur[5]) begin
          mode_nxt = M_IDLE;
        end else begin
          idle_go = 1'b1;
        end
      end
      M_PEND2: begin
        if (op3_cur[5] || dots_hit) begin
          mode_nxt = M_IDLE;
        end else begin
          idle_go = 1'b1;
        end
      end
      default: begin
        idle_go = 1'b1;
      end
    endcase

    // Byte taken between tokens.
    if (idle_go) begin
      mode_nxt = M_IDLE;
      if (c == CH_NL) begin
        line_nxt = line_nxt + 24'd1;
      end else if (is_alpha(c) || c == CH_US) begin
        mode_nxt  = M_IDENT;
        start_nxt = byte_r;
        len_nxt   = LEN_W'(1);
        kw_nxt    = '0;
        kw_nxt[0] = c;
      end else if (c == CH_QUOTE) begin
        mode_nxt  = M_STRING;
        start_nxt = byte_r + 32'd1;
        len_nxt   = '0;
      end else if (is_digit(c)) begin
        mode_nxt  = M_NUMBER;
        start_nxt = byte_r;
        len_nxt   = LEN_W'(1);
        dot_nxt   = 1'b0;
      end else if (is_punct(c) && starts_multi(c)) begin
        mode_nxt  = M_PEND1;
        start_nxt = byte_r;
        p0_nxt    = c;
      end
    end
  end

  // Candidate results: three from the byte, two from the flush, one end marker.
  always_comb begin
    sv = '0;
    sl = '0;
    unique case (mode_r)
      M_IDENT: begin
        if (!is_word(c)) begin
          sv[0] = 1'b1;
          sl[0] = ident_tok(kw_r, len_r, start_r, line_r);
        end
      end
      M_NUMBER: begin
        if (!(is_digit(c) || c == CH_DOT)) begin
          sv[0] = 1'b1;
          sl[0] = mk(dot_r ? K_FLOAT : K_INT, 8'd0, line_r, start_r, 16'(len_r));
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          sv[0] = 1'b1;
          sl[0] = mk(K_STRING, 8'd0, line_r, start_r, 16'(len_r));
        end
      end
      M_PEND1: begin
        if (!(p0_r == CH_SLASH && c == CH_STAR) && !prefix3(p0_r, c)) begin
          sv[0] = 1'b1;
          sl[0] = op2_cur[5] ? mk(K_MULTI, {3'd0, op2_cur[4:0]}, line_r, start_r, 16'd2)
                             : mk(K_PUNCT, p0_r, line_r, start_r, 16'd1);
        end
      end
      M_PEND2: begin
        sv[0] = 1'b1;
        if (op3_cur[5]) begin
          sl[0] = mk(K_MULTI, {3'd0, op3_cur[4:0]}, line_r, start_r, 16'd3);
        end else if (dots_hit) begin
          sl[0] = mk(K_DOTS, 8'd0, line_r, start_r, 16'd3);
        end else if (op2_pp[5]) begin
          sl[0] = mk(K_MULTI, {3'd0, op2_pp[4:0]}, line_r, start_r, 16'd2);
        end else begin
          sl[0] = mk(K_PUNCT, p0_r, line_r, start_r, 16'd1);
          sv[1] = 1'b1;
          sl[1] = mk(K_PUNCT, p1_r, line_r, start_r + 32'd1, 16'd1);
        end
      end
      default: ;
    endcase

    // Single punctuation seen between tokens goes out at once.
    if (idle_go && is_punct(c) && !starts_multi(c) && c != CH_QUOTE && c != CH_US) begin
      sv[2] = 1'b1;
      sl[2] = mk(K_PUNCT, c, line_r, byte_r, 16'd1);
    end

    if (eoi_i) begin
      unique case (mode_nxt)
        M_IDENT: begin
          sv[3] = 1'b1;
          sl[3] = ident_tok(kw_nxt, len_nxt, start_nxt, line_nxt);
        end
        M_NUMBER: begin
          sv[3] = 1'b1;
          sl[3] = mk(dot_nxt ? K_FLOAT : K_INT, 8'd0, line_nxt, start_nxt, 16'(len_nxt));
        end
        M_STRING: begin
          sv[3] = 1'b1;
          sl[3] = mk(K_STRING, 8'd0, line_nxt, start_nxt, 16'(len_nxt));
        end
        M_PEND1: begin
          sv[3] = 1'b1;
          sl[3] = mk(K_PUNCT, p0_nxt, line_nxt, start_nxt, 16'd1);
        end
        M_PEND2: begin
          sv[3] = 1'b1;
          if (op2_fl[5]) begin
            sl[3] = mk(K_MULTI, {3'd0, op2_fl[4:0]}, line_nxt, start_nxt, 16'd2);
          end else begin
            sl[3] = mk(K_PUNCT, p0_nxt, line_nxt, start_nxt, 16'd1);
            sv[4] = 1'b1;
            sl[4] = mk(K_PUNCT, p1_nxt, line_nxt, start_nxt + 32'd1, 16'd1);
          end
        end
        default: ;
      endcase
      sv[5] = 1'b1;
      sl[5] = mk(K_END, 8'd0, line_nxt - 24'd1, byte_r + 32'd1, 16'd0);
    end
  end

  // Pack the valid candidates in order, keeping the first four.
  always_comb begin
    n         = '0;
    bun_o.tok = '0;
    for (int i = 0; i < 6; i++) begin
      if (sv[i] && n < CNT_W'(MAX_RES)) begin
        bun_o.tok[n[RES_IW-1:0]] = sl[i];
        n = n + CNT_W'(1);
      end
    end
    bun_o.cnt = n;
  end

  assign bun_push_o = acc_i && (n != '0);

  // Control state; the last byte of a stream returns it to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (acc_i && eoi_i)) begin
      mode_r <= M_IDLE;
      line_r <= 24'd1;
      byte_r <= '0;
      dot_r  <= 1'b0;
    end else if (acc_i) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      byte_r <= byte_r + 32'd1;
      dot_r  <= dot_nxt;
    end
  end

  // Token payload.
  always_ff @(posedge clk) begin
    if (acc_i) begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
      kw_r    <= kw_nxt;
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && eoi_i) |=> (mode_r == M_IDLE && line_r == 24'd1 && byte_r == 32'd0))
    else $error("scanner did not restart after the last byte");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && eoi_i) |-> (bun_push_o && bun_o.tok[bun_o.cnt - CNT_W'(1)].kind == K_END))
    else $error("last byte did not close with an end result");

endmodule

@@ rtl/stt_queue.sv @@
module stt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  stt_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output stt_pkg::bundle_t data_o
);
  import stt_pkg::*;

  bundle_t        mem [QDEPTH];
  logic [QIW-1:0] wr_r, rd_r;
  logic [QCW-1:0] cnt_r;

  assign full_o  = (cnt_r == QCW'(QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign data_o  = mem[rd_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wr_r <= wr_r + QIW'(1);
      end
      if (pop_i) begin
        rd_r <= rd_r + QIW'(1);
      end
      cnt_r <= cnt_r + QCW'(push_i) - QCW'(pop_i);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_r] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

@@ rtl/stt_back.sv @@
module stt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty_i,
  input  stt_pkg::bundle_t q_data_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output stt_pkg::tok_t    tok_o,
  output logic             last_o
);
  import stt_pkg::*;

  logic              valid_r;
  bundle_t           bun_r;
  logic [RES_IW-1:0] idx_r;
  logic              take;

  assign last_o  = (idx_r == RES_IW'(bun_r.cnt - CNT_W'(1)));
  assign take    = valid_r && pop_i;
  assign q_pop_o = !q_empty_i && (!valid_r || (take && last_o));
  assign empty_o = !valid_r;
  assign tok_o   = bun_r.tok[idx_r];

  // Walk through the results of one byte, then fetch the next set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (q_pop_o) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (last_o) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + RES_IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      bun_r <= q_data_i;
    end
  end

  a_set_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (bun_r.cnt != '0 && {1'b0, idx_r} < bun_r.cnt))
    else $error("result index outside the held set");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !last_o && !q_pop_o) |=> (valid_r && idx_r == $past(idx_r) + RES_IW'(1)))
    else $error("result index did not advance");

endmodule

@@ rtl/source_text_tokenizer.sv @@
// Tokenizer for a byte stream of source text, one byte per request.
// Throughput: one byte per cycle while the queue is not full; results leave one per
// cycle while the receiver pops, buffered by a 4-entry queue.
// A byte's results reach the result ports through the queue and then the result
// holding register. Reset: synchronous active-low rst_n empties the queue and starts
// a new stream at line 1, offset 0; a byte marked end_of_input starts one after its results.
module source_text_tokenizer #(
  parameter int unsigned LEN_MAX       = stt_pkg::LEN_MAX_DEF,
  parameter int unsigned KEYWORD_CHARS = stt_pkg::KW_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_token_code,
  output logic [23:0] out_line_number,
  output logic [31:0] out_start_offset,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);
  import stt_pkg::*;

  bundle_t f_bun, q_data;
  logic    f_push, q_full, q_empty, q_pop, acc;
  tok_t    tok;

  assign full = q_full;
  assign acc  = push && !q_full;

  stt_front #(
    .LEN_MAX      (LEN_MAX),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_i     (acc),
    .chr_i     (in_byte),
    .eoi_i     (in_end_of_input),
    .bun_o     (f_bun),
    .bun_push_o(f_push)
  );

  stt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (f_push),
    .data_i (f_bun),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_data)
  );

  stt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty_i(q_empty),
    .q_data_i (q_data),
    .q_pop_o  (q_pop),
    .empty_o  (empty),
    .pop_i    (pop),
    .tok_o    (tok),
    .last_o   (out_last_of_run)
  );

  assign out_token_kind   = tok.kind;
  assign out_token_code   = tok.code;
  assign out_line_number  = tok.line;
  assign out_start_offset = tok.start;
  assign out_token_length = tok.len;

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import stt_pkg::*;

  // One expected or observed token.
  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  code;
    logic [23:0] line;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        in_end_of_input;
  logic        empty;
  logic        pop;
  logic [3:0]  out_token_kind;
  logic [7:0]  out_token_code;
  logic [23:0] out_line_number;
  logic [31:0] out_start_offset;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  source_text_tokenizer i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_byte(in_byte),
    .in_end_of_input(in_end_of_input), .empty(empty), .pop(pop),
    .out_token_kind(out_token_kind), .out_token_code(out_token_code),
    .out_line_number(out_line_number), .out_start_offset(out_start_offset),
    .out_token_length(out_token_length), .out_last_of_run(out_last_of_run)
  );

  // Tokens still owed by the block, oldest first.
  token_t pending_tokens[$];
  token_t run_tokens[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     hold_request;
  int     burst_left;

  // Scanner state mirrored from the block.
  mode_t       scan_state;
  logic [23:0] cur_line;
  logic [31:0] byte_count;
  logic [31:0] tok_start;
  logic [15:0] tok_len;
  logic [7:0]  word_prefix [8];
  logic [7:0]  held_char [2];
  logic        dot_star_seen;

  string keywords [14] = '{"if", "else", "elif", "while", "do", "func", "return",
                           "switch", "case", "continue", "break", "for", "struct",
                           "cfunc"};
  string operators [23] = '{"&&", "||", ">>", "<<", "++", "+=", "--", "-=", "*=",
                            "/=", "%=", "&=", "|=", "^=", ">>=", "<<=", "->=",
                            "==", "!=", ">=", "<=", "->", ":="};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit letter(logic [7:0] c);
    return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit punct_char(logic [7:0] c);
    return (c >= 33 && c <= 47) || (c >= 58 && c <= 64) ||
           (c >= 91 && c <= 96) || (c >= 123 && c <= 126);
  endfunction

  function automatic bit may_combine(logic [7:0] c);
    string set;
    set = "&|><+-*/%^=!:.";
    for (int i = 0; i < set.len(); i++) begin
      if (set[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Returns the operator index, or -1 when the sequence is no operator.
  function automatic int operator_index(logic [7:0] a, logic [7:0] b, logic [7:0] c, int n);
    for (int i = 0; i < 23; i++) begin
      if (operators[i].len() == n && operators[i][0] == a && operators[i][1] == b &&
          (n == 2 || operators[i][2] == c)) return i;
    end
    return -1;
  endfunction

  function automatic bit three_char_prefix(logic [7:0] a, logic [7:0] b);
    return (a == ">" && b == ">") || (a == "<" && b == "<") ||
           (a == "-" && b == ">") || (a == "." && b == ".");
  endfunction

  function automatic void add_token(kind_t k, logic [7:0] code, logic [23:0] line,
                                    logic [31:0] start, logic [15:0] len);
    token_t t;
    t.kind = k;
    t.code = code;
    t.line = line;
    t.start = start;
    t.len = len;
    t.last = 1'b0;
    if (run_tokens.size() < 4) run_tokens.push_back(t);
  endfunction

  function automatic void clear_scanner();
    scan_state = M_IDLE;
    cur_line = 24'd1;
    byte_count = '0;
    tok_start = '0;
    tok_len = '0;
    foreach (word_prefix[i]) word_prefix[i] = '0;
    held_char[0] = '0;
    held_char[1] = '0;
    dot_star_seen = 1'b0;
  endfunction

  function automatic void grow_length();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  // Closes an identifier, which is a keyword when its whole text matches one.
  function automatic void close_word();
    bit hit;
    if (tok_len <= 16'd8) begin
      for (int i = 0; i < 14; i++) begin
        if (keywords[i].len() == int'(tok_len)) begin
          hit = 1'b1;
          for (int j = 0; j < keywords[i].len(); j++) begin
            if (keywords[i][j] != word_prefix[j]) hit = 1'b0;
          end
          if (hit) begin
            add_token(K_KEYWORD, 8'(i), cur_line, tok_start, tok_len);
            return;
          end
        end
      end
    end
    add_token(K_IDENT, 8'd0, cur_line, tok_start, tok_len);
  endfunction

  function automatic void close_pair();
    int k;
    k = operator_index(held_char[0], held_char[1], 8'd0, 2);
    if (k >= 0) begin
      add_token(K_MULTI, 8'(k), cur_line, tok_start, 16'd2);
    end else begin
      add_token(K_PUNCT, held_char[0], cur_line, tok_start, 16'd1);
      add_token(K_PUNCT, held_char[1], cur_line, tok_start + 32'd1, 16'd1);
    end
  endfunction

  function automatic void close_number();
    add_token(dot_star_seen ? K_FLOAT : K_INT, 8'd0, cur_line, tok_start, tok_len);
  endfunction

  // Handles a byte that arrives between tokens.
  function automatic void start_token(logic [7:0] c, logic [31:0] off);
    scan_state = M_IDLE;
    if (c == 8'h0A) begin
      cur_line++;
    end else if (c == 8'h09 || c == 8'h20 || c == 8'h0D) begin
    end else if (letter(c) || c == "_") begin
      scan_state = M_IDENT;
      tok_start = off;
      tok_len = 16'd1;
      foreach (word_prefix[i]) word_prefix[i] = '0;
      word_prefix[0] = c;
    end else if (c == 8'h22) begin
      scan_state = M_STRING;
      tok_start = off + 32'd1;
      tok_len = '0;
    end else if (digit(c)) begin
      scan_state = M_NUMBER;
      tok_start = off;
      tok_len = 16'd1;
      dot_star_seen = 1'b0;
    end else if (punct_char(c)) begin
      if (may_combine(c)) begin
        scan_state = M_PEND1;
        tok_start = off;
        held_char[0] = c;
      end else begin
        add_token(K_PUNCT, c, cur_line, off, 16'd1);
      end
    end
  endfunction

  // Works out the tokens caused by one accepted byte and queues them.
  function automatic void predict_tokens(logic [7:0] c, logic eoi);
    logic [31:0] off;
    int k;
    off = byte_count;
    run_tokens.delete();
    case (scan_state)
      M_IDENT: begin
        if (letter(c) || digit(c) || c == "_") begin
          if (tok_len < 16'd8) word_prefix[tok_len] = c;
          grow_length();
        end else begin
          close_word();
          start_token(c, off);
        end
      end
      M_NUMBER: begin
        if (digit(c) || c == ".") begin
          if (c == ".") dot_star_seen = 1'b1;
          grow_length();
        end else begin
          close_number();
          start_token(c, off);
        end
      end
      M_STRING: begin
        if (c == 8'h22) begin
          add_token(K_STRING, 8'd0, cur_line, tok_start, tok_len);
          scan_state = M_IDLE;
        end else begin
          grow_length();
        end
      end
      M_COMMENT: begin
        if (c == "/" && dot_star_seen) scan_state = M_IDLE;
        else if (c == 8'h0A) cur_line++;
        dot_star_seen = (c == "*") && scan_state != M_IDLE;
      end
      M_PEND1: begin
        k = operator_index(held_char[0], c, 8'd0, 2);
        if (held_char[0] == "/" && c == "*") begin
          scan_state = M_COMMENT;
          dot_star_seen = 1'b0;
        end else if (three_char_prefix(held_char[0], c)) begin
          held_char[1] = c;
          scan_state = M_PEND2;
        end else if (k >= 0) begin
          add_token(K_MULTI, 8'(k), cur_line, tok_start, 16'd2);
          scan_state = M_IDLE;
        end else begin
          add_token(K_PUNCT, held_char[0], cur_line, tok_start, 16'd1);
          start_token(c, off);
        end
      end
      M_PEND2: begin
        k = operator_index(held_char[0], held_char[1], c, 3);
        if (k >= 0) begin
          add_token(K_MULTI, 8'(k), cur_line, tok_start, 16'd3);
          scan_state = M_IDLE;
        end else if (held_char[0] == "." && held_char[1] == "." && c == ".") begin
          add_token(K_DOTS, 8'd0, cur_line, tok_start, 16'd3);
          scan_state = M_IDLE;
        end else begin
          close_pair();
          start_token(c, off);
        end
      end
      default: start_token(c, off);
    endcase
    byte_count++;
    // The last byte flushes the open token, reports the totals and restarts.
    if (eoi) begin
      case (scan_state)
        M_IDENT:  close_word();
        M_NUMBER: close_number();
        M_STRING: add_token(K_STRING, 8'd0, cur_line, tok_start, tok_len);
        M_PEND1:  add_token(K_PUNCT, held_char[0], cur_line, tok_start, 16'd1);
        M_PEND2:  close_pair();
        default: ;
      endcase
      add_token(K_END, 8'd0, cur_line - 24'd1, byte_count, 16'd0);
      clear_scanner();
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1'b1;
    foreach (run_tokens[i]) pending_tokens.push_back(run_tokens[i]);
  endfunction

  // Sends one request in bursts with random gaps in between.
  task automatic send_byte(logic [7:0] c, logic eoi);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
    end
    burst_left--;
    push = 1'b1;
    in_byte = c;
    in_end_of_input = eoi;
    // Full only changes at rising edges, so its value here decides the next edge.
    while (full) @(negedge clk);
    @(posedge clk);
    predict_tokens(c, eoi);
  endtask

  task automatic send_text(string s, bit eoi_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eoi_at_end && i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // Keywords, every operator, numbers, strings, comments and skipped bytes.
  task automatic test_directed();
    send_text("if else elif while do func return switch case continue break", 0);
    send_text(" for struct cfunc cfuncs continue1 abcdefghij _x9 Z\n", 0);
    send_text("&& || >> << ++ += -- -= *= /= %= &= |= ^= >>= <<= ->= == != >= ", 0);
    send_text("<= -> := ... .. >>x <a -; ,( 12 3.4.5 7a\t\r\n", 0);
    send_text("\"ab\ncd\" /* c\n** / */ x/**/y", 0);
    send_byte(8'h00, 0);
    send_byte(8'hFF, 0);
    send_byte(8'h80, 0);
    send_byte(8'h7F, 0);
    send_text("ab", 0);
    send_byte(8'h01, 0);
    send_text("9", 1);
    send_text("x \"open string", 1);
    send_text("a /* open comment", 1);
    send_text(">>", 1);
    send_text("-", 1);
    send_byte(8'hFF, 1);
  endtask

  function automatic string random_word(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
        1: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
        2: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        default: s = {s, "_"};
      endcase
    end
    return s;
  endfunction

  function automatic string random_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  // Mostly well-formed tokens with random content, plus raw noise bytes.
  task automatic test_random_text(int n_bytes);
    string piece;
    string seps [5] = '{" ", "\n", "\t", "\r", ""};
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(0, 9))
        0: piece = keywords[$urandom_range(0, 13)];
        1: piece = {string'(8'("a" + $urandom_range(0, 25))),
                    random_word($urandom_range(0, 11))};
        2: piece = random_digits($urandom_range(1, 5));
        3: piece = {random_digits($urandom_range(1, 3)), ".", random_digits($urandom_range(0, 3))};
        4: piece = {"\"", random_word($urandom_range(0, 6)), "\""};
        5: piece = operators[$urandom_range(0, 22)];
        6: piece = {"/*", random_word($urandom_range(0, 5)), "\n*", "*/"};
        7: piece = "(){};,[]#@?~`$'\\...";
        8: piece = "";
        default: piece = seps[$urandom_range(0, 3)];
      endcase
      if (piece == "") begin
        send_byte(8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)) & ($urandom_range(0, 20) == 0));
        sent++;
      end else begin
        if (piece.len() > 7) piece = piece.substr(0, $urandom_range(0, piece.len() - 1));
        send_text({piece, seps[$urandom_range(0, 4)]}, $urandom_range(0, 25) == 0);
        sent += piece.len() + 1;
      end
    end
    send_text(" ", 1);
  endtask

  // The receiver holds off while the sender keeps offering punctuation.
  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_text("; ", 0);
    send_text("x", 1);
    wait_drained();
  endtask

  // Receiver: stalls on its own pattern, or holds off for a long stretch.
  initial begin
    int hold_left;
    int phase;
    pop = 1'b0;
    hold_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else if ((phase / 80) % 3 == 0) begin
        pop = 1'b1;
      end else begin
        pop = ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Compares every accepted result with the oldest expected one.
  always @(posedge clk) begin
    token_t e;
    if (rst_n && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected token kind %0d at offset %0d",
                                       out_token_kind, out_start_offset);
      end else begin
        e = pending_tokens.pop_front();
        if (out_token_kind !== e.kind || out_token_code !== e.code ||
            out_line_number !== e.line || out_start_offset !== e.start ||
            out_token_length !== e.len || out_last_of_run !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Expected kind %0d code %0d line %0d start %0d len %0d last %0d",
                     e.kind, e.code, e.line, e.start, e.len, e.last);
            $display("Got      kind %0d code %0d line %0d start %0d len %0d last %0d",
                     out_token_kind, out_token_code, out_line_number, out_start_offset,
                     out_token_length, out_last_of_run);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which nothing is accepted although work is owed.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (!push && pending_tokens.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_byte = '0;
    in_end_of_input = 1'b0;
    hold_request = 1'b0;
    burst_left = 0;
    clear_scanner();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_drained();
    test_backpressure();
    test_random_text(60);
    wait_drained();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
